/* rtl/wesd_pkg.sv */
// shared types and constants for the wheel encoder speed and drive unit
package wesd_pkg;

  localparam int RPM_FRAC_BITS = 8;

  localparam int NOW_W    = 32;
  localparam int POS_W    = 32;
  localparam int SPEED_W  = 21;
  localparam int QUO_W    = 20;               // saturated magnitude bits
  localparam int TICKS_W  = 13;
  localparam int STALE_W  = 20;
  localparam int MINP_W   = 16;
  localparam int DRIVE_W  = 11;
  localparam int DUTY_W   = 8;
  localparam int DEN_W    = NOW_W + TICKS_W;  // period * ticks
  localparam int DSH_W    = DEN_W + QUO_W;    // divisor shifted for the top step
  localparam int NUM_W    = 40;               // holds 60e6 << RPM_FRAC_BITS up to 14

  localparam logic [NUM_W-1:0] SPEED_NUM = NUM_W'(64'd60000000 << RPM_FRAC_BITS);
  localparam logic [QUO_W-1:0] MAG_LIMIT = {QUO_W{1'b1}};

  localparam logic signed [DRIVE_W-1:0] DRIVE_HI = 11'sd255;
  localparam logic signed [DRIVE_W-1:0] DRIVE_LO = -11'sd255;
  localparam logic signed [8:0]         DUTY_TOP = 9'sd255;

  // input request codes
  localparam logic [1:0] REQ_EDGE  = 2'd0;
  localparam logic [1:0] REQ_QUERY = 2'd1;
  localparam logic [1:0] REQ_DRIVE = 2'd2;

  // result kinds
  localparam logic KIND_SPEED = 1'b0;
  localparam logic KIND_DRIVE = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_REVERSE = 2'd0;
  localparam logic [1:0] CFG_STALE   = 2'd1;
  localparam logic [1:0] CFG_MINPER  = 2'd2;
  localparam logic [1:0] CFG_TICKS   = 2'd3;

  typedef enum logic [1:0] {
    CMD_EDGE,
    CMD_QUERY,
    CMD_DRIVE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [NOW_W-1:0]   now_us;
    logic               dir_neg;
    logic               drive_dir;
    logic [DUTY_W-1:0]  drive_duty;
  } cmd_t;

  typedef struct packed {
    logic [STALE_W-1:0] stale_timeout_us;
    logic [MINP_W-1:0]  min_period_us;
    logic [TICKS_W-1:0] ticks_per_rev;
  } speed_cfg_t;

endpackage

/* rtl/wheel_encoder_speed_drive_unit.sv */
// top level of the wheel encoder speed meter with pwm drive
// One motor wheel block. Input transfers are encoder edges, speed queries and
// drive commands, each stamped with a free-running microsecond time. A front
// end decodes every transfer (and already maps a drive command to direction
// pin and duty), a two-entry queue holds it, and the back end works through
// the queue in order. An encoder edge is handled on taking it from the queue
// and gives no result; a drive command then loads the output register; a
// speed query that reads zero (stale edge, short or zero period) does the
// same, otherwise it steps through: taking it from the queue, period *
// ticks_per_rev, a saturation check, a 20-step restoring divider of 60e6 << 8
// by that product (one quotient bit a cycle) and loading the output register.
// A query whose quotient saturates makes a single divider pass that subtracts
// nothing. The loading step repeats while the output register still holds an
// unaccepted result. That divider sets the sustained rate for queries. Results
// sit in an output register so the back end keeps draining the queue while a
// result waits. Configuration writes belong in idle periods only.
module wheel_encoder_speed_drive_unit import wesd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [19:0] cfg_wdata,
  // request stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  input  logic [47:0] in_tdata,   // [31:0] now_us, [32] dir_level, [43:33] drive_value
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic        out_tuser,  // [0] result_kind
  output logic [63:0] out_tdata   // [20:0] speed_rpm_q8, [52:21] position_count,
                                  // [53] drive_dir, [61:54] drive_duty
);

  // configuration registers
  logic               reverse_r;
  logic [STALE_W-1:0] stale_r;
  logic [MINP_W-1:0]  minper_r;
  logic [TICKS_W-1:0] ticks_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reverse_r <= 1'b0;
      stale_r   <= STALE_W'(10000);
      minper_r  <= MINP_W'(500);
      ticks_r   <= TICKS_W'(500);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_REVERSE: reverse_r <= cfg_wdata[0];
        CFG_STALE:   stale_r   <= cfg_wdata[STALE_W-1:0];
        CFG_MINPER:  minper_r  <= cfg_wdata[MINP_W-1:0];
        CFG_TICKS:   ticks_r   <= cfg_wdata[TICKS_W-1:0];
        default:     reverse_r <= reverse_r;
      endcase
    end
  end

  speed_cfg_t scfg;
  assign scfg.stale_timeout_us = stale_r;
  assign scfg.min_period_us    = minper_r;
  assign scfg.ticks_per_rev    = ticks_r;

  // front end to queue
  logic q_full;
  logic q_push;
  cmd_t q_cmd_in;

  wesd_front u_front (
    .in_valid          (in_tvalid),
    .req_type          (in_tuser),
    .now_us            (in_tdata[31:0]),
    .dir_level         (in_tdata[32]),
    .drive_value       (in_tdata[43:33]),
    .reverse_direction (reverse_r),
    .q_full            (q_full),
    .in_ready          (in_tready),
    .q_push            (q_push),
    .q_cmd             (q_cmd_in)
  );

  // queue to back end
  logic q_pop;
  logic q_not_empty;
  cmd_t q_head;

  wesd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_cmd_in),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_cmd  (q_head)
  );

  // back end and result packing
  logic [SPEED_W-1:0] res_speed;
  logic [POS_W-1:0]   res_pos;
  logic               res_dir;
  logic [DUTY_W-1:0]  res_duty;

  wesd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_not_empty    (q_not_empty),
    .q_cmd          (q_head),
    .q_pop          (q_pop),
    .scfg           (scfg),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_kind       (out_tuser),
    .out_speed      (res_speed),
    .out_position   (res_pos),
    .out_drive_dir  (res_dir),
    .out_drive_duty (res_duty)
  );

  assign out_tdata = {2'b00, res_duty, res_dir, res_pos, res_speed};

endmodule

/* rtl/wesd_front.sv */
// front end: decodes each input transfer into a command for the queue
module wesd_front import wesd_pkg::*; (
  input  logic                      in_valid,
  input  logic [1:0]                req_type,
  input  logic [NOW_W-1:0]          now_us,
  input  logic                      dir_level,
  input  logic signed [DRIVE_W-1:0] drive_value,
  input  logic                      reverse_direction,
  input  logic                      q_full,
  output logic                      in_ready,
  output logic                      q_push,
  output cmd_t                      q_cmd
);

  logic signed [8:0] v_sat;
  logic signed [8:0] v_dir;
  logic signed [8:0] v_low;

  assign in_ready = !q_full;

  always_comb begin
    if (drive_value > DRIVE_HI) begin
      v_sat = 9'sd255;
    end else if (drive_value < DRIVE_LO) begin
      v_sat = -9'sd255;
    end else begin
      v_sat = drive_value[8:0];
    end
    v_dir = reverse_direction ? -v_sat : v_sat;
    v_low = DUTY_TOP + v_dir;
  end

  always_comb begin
    q_cmd.now_us     = now_us;
    q_cmd.dir_neg    = dir_level ^ reverse_direction;
    q_cmd.drive_dir  = 1'b0;
    q_cmd.drive_duty = '0;
    q_cmd.kind       = CMD_EDGE;
    q_push           = 1'b0;
    unique case (req_type)
      REQ_EDGE: begin
        q_cmd.kind = CMD_EDGE;
        q_push     = in_valid && in_ready;
      end
      REQ_QUERY: begin
        q_cmd.kind = CMD_QUERY;
        q_push     = in_valid && in_ready;
      end
      REQ_DRIVE: begin
        q_cmd.kind = CMD_DRIVE;
        q_push     = in_valid && in_ready;
        if (v_dir > 9'sd0) begin
          q_cmd.drive_duty = v_dir[7:0];
        end else if (v_dir < 9'sd0) begin
          q_cmd.drive_dir  = 1'b1;
          q_cmd.drive_duty = v_low[7:0];
        end
      end
      default: begin
        q_push = 1'b0;   // unknown request is dropped
      end
    endcase
  end

endmodule

/* rtl/wesd_queue.sv */
// two-entry command queue between front and back
module wesd_queue import wesd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic not_empty,
  output cmd_t head_cmd
);

  cmd_t       mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head_cmd  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

/* rtl/wesd_back.sv */
// back end: encoder state, speed divider and output register
module wesd_back import wesd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_not_empty,
  input  cmd_t               q_cmd,
  output logic               q_pop,
  input  speed_cfg_t         scfg,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_kind,
  output logic [SPEED_W-1:0] out_speed,
  output logic [POS_W-1:0]   out_position,
  output logic               out_drive_dir,
  output logic [DUTY_W-1:0]  out_drive_duty
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SAT,
    ST_DIV,
    ST_OUT
  } state_t;

  state_t             state_r, state_nxt;
  logic [NOW_W-1:0]   last_edge_r, last_edge_nxt;
  logic [NOW_W-1:0]   period_r, period_nxt;
  logic               dir_neg_r, dir_neg_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [DEN_W-1:0]   den_r, den_nxt;
  logic [DSH_W-1:0]   dsh_r, dsh_nxt;
  logic [NUM_W-1:0]   rem_r, rem_nxt;
  logic [QUO_W-1:0]   quo_r, quo_nxt;
  logic [4:0]         cnt_r, cnt_nxt;
  logic               res_kind_r, res_kind_nxt;
  logic [SPEED_W-1:0] res_speed_r, res_speed_nxt;
  logic               res_dir_r, res_dir_nxt;
  logic [DUTY_W-1:0]  res_duty_r, res_duty_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_kind_r, out_kind_nxt;
  logic [SPEED_W-1:0] out_speed_r, out_speed_nxt;
  logic [POS_W-1:0]   out_pos_r, out_pos_nxt;
  logic               out_dir_r, out_dir_nxt;
  logic [DUTY_W-1:0]  out_duty_r, out_duty_nxt;

  logic [NOW_W-1:0]   age;
  logic               speed_ok;
  logic [TICKS_W-1:0] ticks_eff;
  logic               step_ge;
  logic [QUO_W-1:0]   quo_fin;
  logic [SPEED_W-1:0] mag_ext;

  assign age       = q_cmd.now_us - last_edge_r;
  assign speed_ok  = (age <= NOW_W'(scfg.stale_timeout_us)) &&
                     (period_r >= NOW_W'(scfg.min_period_us)) &&
                     (period_r != '0);
  assign ticks_eff = (scfg.ticks_per_rev == '0) ? TICKS_W'(1) : scfg.ticks_per_rev;
  assign step_ge   = (dsh_r <= DSH_W'(rem_r));
  assign quo_fin   = (quo_r == MAG_LIMIT && dsh_r == '1) ? MAG_LIMIT :
                     {quo_r[QUO_W-2:0], step_ge};
  assign mag_ext   = {1'b0, quo_fin};

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_speed      = out_speed_r;
  assign out_position   = out_pos_r;
  assign out_drive_dir  = out_dir_r;
  assign out_drive_duty = out_duty_r;

  always_comb begin
    state_nxt     = state_r;
    last_edge_nxt = last_edge_r;
    period_nxt    = period_r;
    dir_neg_nxt   = dir_neg_r;
    pos_nxt       = pos_r;
    den_nxt       = den_r;
    dsh_nxt       = dsh_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    res_kind_nxt  = res_kind_r;
    res_speed_nxt = res_speed_r;
    res_dir_nxt   = res_dir_r;
    res_duty_nxt  = res_duty_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_kind_nxt  = out_kind_r;
    out_speed_nxt = out_speed_r;
    out_pos_nxt   = out_pos_r;
    out_dir_nxt   = out_dir_r;
    out_duty_nxt  = out_duty_r;
    q_pop         = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (q_not_empty) begin
          q_pop = 1'b1;
          unique case (q_cmd.kind)
            CMD_EDGE: begin
              period_nxt    = q_cmd.now_us - last_edge_r;
              last_edge_nxt = q_cmd.now_us;
              dir_neg_nxt   = q_cmd.dir_neg;
              pos_nxt       = q_cmd.dir_neg ? pos_r - POS_W'(1) : pos_r + POS_W'(1);
            end
            CMD_QUERY: begin
              res_kind_nxt  = KIND_SPEED;
              res_speed_nxt = '0;
              res_dir_nxt   = 1'b0;
              res_duty_nxt  = '0;
              state_nxt     = speed_ok ? ST_MUL : ST_OUT;
            end
            CMD_DRIVE: begin
              res_kind_nxt  = KIND_DRIVE;
              res_speed_nxt = '0;
              res_dir_nxt   = q_cmd.drive_dir;
              res_duty_nxt  = q_cmd.drive_duty;
              state_nxt     = ST_OUT;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_MUL: begin
        den_nxt   = DEN_W'(period_r) * DEN_W'(ticks_eff);
        state_nxt = ST_SAT;
      end
      ST_SAT: begin
        // quotient at or above 2^QUO_W saturates without dividing
        if ((DSH_W'(den_r) << QUO_W) <= DSH_W'(SPEED_NUM)) begin
          quo_nxt   = MAG_LIMIT;
          state_nxt = ST_DIV;
          cnt_nxt   = '0;
          dsh_nxt   = '1;   // no step can subtract
        end else begin
          quo_nxt   = '0;
          cnt_nxt   = 5'(QUO_W - 1);
          dsh_nxt   = DSH_W'(den_r) << (QUO_W - 1);
          state_nxt = ST_DIV;
        end
        rem_nxt = SPEED_NUM;
      end
      ST_DIV: begin
        // one restoring step per cycle, msb first
        if (step_ge) begin
          rem_nxt = rem_r - NUM_W'(dsh_r);
        end
        quo_nxt = quo_fin;
        dsh_nxt = dsh_r >> 1;
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == '0) begin
          res_speed_nxt = dir_neg_r ? (SPEED_W'(0) - mag_ext) : mag_ext;
          state_nxt     = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = res_kind_r;
          out_speed_nxt = res_speed_r;
          out_pos_nxt   = pos_r;
          out_dir_nxt   = res_dir_r;
          out_duty_nxt  = res_duty_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      last_edge_r <= '0;
      period_r    <= '0;
      dir_neg_r   <= 1'b0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_edge_r <= last_edge_nxt;
      period_r    <= period_nxt;
      dir_neg_r   <= dir_neg_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
    den_r       <= den_nxt;
    dsh_r       <= dsh_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    cnt_r       <= cnt_nxt;
    res_kind_r  <= res_kind_nxt;
    res_speed_r <= res_speed_nxt;
    res_dir_r   <= res_dir_nxt;
    res_duty_r  <= res_duty_nxt;
    out_kind_r  <= out_kind_nxt;
    out_speed_r <= out_speed_nxt;
    out_pos_r   <= out_pos_nxt;
    out_dir_r   <= out_dir_nxt;
    out_duty_r  <= out_duty_nxt;
  end

endmodule

/* verif/tb_wheel_encoder_speed_drive_unit.sv */
// testbench for the wheel encoder speed meter with pwm drive: predicted results vs the stream
import wesd_pkg::*;

typedef struct packed {
  logic        kind;
  logic [20:0] speed;
  logic [31:0] position;
  logic        dir;
  logic [7:0]  duty;
} wheel_result_t;

class wheel_scoreboard;
  localparam longint unsigned SPEED_LIMIT = 64'd1048575;
  localparam int DRIVE_LIMIT = 255;

  wheel_result_t due_q[$];
  // register copies
  bit        reverse_on;
  bit [19:0] stale_limit_us;
  bit [15:0] min_period_us;
  bit [12:0] ticks_rev;
  // wheel state
  bit [31:0] last_tick_us;
  bit [31:0] tick_period_us;
  bit [31:0] position;
  bit        moving_back;
  int        mismatches;

  function new();
    reverse_on     = 1'b0;
    stale_limit_us = 20'd10000;
    min_period_us  = 16'd500;
    ticks_rev      = 13'd500;
    last_tick_us   = '0;
    tick_period_us = '0;
    position       = '0;
    moving_back    = 1'b0;
    mismatches     = 0;
  endfunction

  function void set_reg(bit [1:0] idx, bit [19:0] val);
    case (idx)
      CFG_REVERSE: reverse_on     = val[0];
      CFG_STALE:   stale_limit_us = val;
      CFG_MINPER:  min_period_us  = val[15:0];
      CFG_TICKS:   ticks_rev      = val[12:0];
      default: ;
    endcase
  endfunction

  function int outstanding();
    return due_q.size();
  endfunction

  // 60e6 << frac / (period * ticks), magnitude saturated, sign from direction
  function bit [20:0] rpm_q8();
    longint unsigned ticks_used, denom, mag;
    ticks_used = (ticks_rev == 0) ? 64'd1 : 64'(ticks_rev);
    denom = 64'(tick_period_us) * ticks_used;
    mag = (64'd60000000 << RPM_FRAC_BITS) / denom;
    if (mag > SPEED_LIMIT) mag = SPEED_LIMIT;
    if (moving_back) mag = 64'd0 - mag;
    return mag[20:0];
  endfunction

  function void note_input(bit [1:0] req, bit [31:0] now, bit dir, bit signed [10:0] drv);
    wheel_result_t r;
    bit [31:0] age;
    int v;
    r = '0;
    case (req)
      REQ_EDGE: begin
        tick_period_us = now - last_tick_us;
        last_tick_us   = now;
        if (dir ^ reverse_on) begin
          position    = position - 1;
          moving_back = 1'b1;
        end else begin
          position    = position + 1;
          moving_back = 1'b0;
        end
      end
      REQ_QUERY: begin
        age = now - last_tick_us;
        r.kind = KIND_SPEED;
        r.position = position;
        if (age <= stale_limit_us && tick_period_us >= min_period_us && tick_period_us != 0)
          r.speed = rpm_q8();
        due_q.push_back(r);
      end
      REQ_DRIVE: begin
        v = drv;
        if (v > DRIVE_LIMIT) v = DRIVE_LIMIT;
        if (v < -DRIVE_LIMIT) v = -DRIVE_LIMIT;
        if (reverse_on) v = -v;
        r.kind = KIND_DRIVE;
        r.position = position;
        if (v > 0) begin
          r.duty = v[7:0];
        end else if (v < 0) begin
          r.dir  = 1'b1;
          r.duty = 8'(DRIVE_LIMIT + v);
        end
        due_q.push_back(r);
      end
      default: ;
    endcase
  endfunction

  task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    $display("mismatch %s: got 0x%0h, want 0x%0h", what, got, want);
  endtask

  task check_result(logic kind, logic [63:0] data);
    wheel_result_t want;
    if (due_q.size() == 0) begin
      report_mismatch("result with nothing due", data, '0);
      return;
    end
    want = due_q.pop_front();
    if (kind !== want.kind) report_mismatch("result_kind", 64'(kind), 64'(want.kind));
    if (data[20:0] !== want.speed)
      report_mismatch("speed_rpm_q8", 64'(data[20:0]), 64'(want.speed));
    if (data[52:21] !== want.position)
      report_mismatch("position_count", 64'(data[52:21]), 64'(want.position));
    if (data[53] !== want.dir) report_mismatch("drive_dir", 64'(data[53]), 64'(want.dir));
    if (data[61:54] !== want.duty)
      report_mismatch("drive_duty", 64'(data[61:54]), 64'(want.duty));
  endtask
endclass

module tb_wheel_encoder_speed_drive_unit;
  // request code the block must ignore
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  // settle time after the last result, so that edges still in the two-entry queue retire
  localparam int SETTLE_CYCLES = 64;
  localparam int unsigned RUN_LIMIT = 500000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [19:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser = '0;   // [1:0] req_type
  logic [47:0] in_tdata = '0;   // [31:0] now_us, [32] dir_level, [43:33] drive_value
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        out_tuser;       // [0] result_kind
  logic [63:0] out_tdata;       // [20:0] speed, [52:21] position, [53] drive_dir, [61:54] duty

  wheel_scoreboard sb;
  int unsigned cycle_count = 0;
  bit [31:0]   stamp_us = '0;   // running microsecond clock for well-formed sequences
  bit          send_burst = 1'b0;
  bit          recv_burst = 1'b0;

  wheel_encoder_speed_drive_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // one register write per clock; caller lowers cfg_we after the last one
  task write_reg(logic [1:0] idx, logic [19:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task apply_config(bit rev, bit [19:0] stale, bit [15:0] minp, bit [12:0] ticks);
    write_reg(CFG_REVERSE, {19'd0, rev});
    write_reg(CFG_STALE, stale);
    write_reg(CFG_MINPER, {4'd0, minp});
    write_reg(CFG_TICKS, {7'd0, ticks});
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // one input transfer, with a random gap in front unless in a burst stretch
  task send_item(logic [1:0] req, logic [31:0] now, logic dir, logic signed [10:0] drv);
    int gap;
    if ($urandom_range(0, 39) == 0) send_burst = ~send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {4'd0, drv, dir, now};
    do @(posedge clk); while (!in_tready);
    sb.note_input(req, now, dir, drv);
  endtask

  // stop sending, let every result arrive, then give queued edges time to retire
  task drain();
    in_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task directed_items();
    // zero period right after reset
    send_item(REQ_QUERY, 32'd0, 1'b0, 11'sd0);
    // drive extremes and the zero, clamp and full-scale cases
    send_item(REQ_DRIVE, 32'd10, 1'b0, 11'sd1023);
    send_item(REQ_DRIVE, 32'd11, 1'b1, -11'sd1024);
    send_item(REQ_DRIVE, 32'd12, 1'b0, 11'sd0);
    send_item(REQ_DRIVE, 32'd13, 1'b0, 11'sd255);
    send_item(REQ_DRIVE, 32'd14, 1'b0, -11'sd255);
    send_item(REQ_DRIVE, 32'd15, 1'b0, -11'sd1);
    // plain forward edge, then a live speed reading
    send_item(REQ_EDGE, 32'd1000, 1'b0, 11'sd0);
    send_item(REQ_QUERY, 32'd1500, 1'b0, 11'sd0);
    // period shorter than the noise floor
    send_item(REQ_EDGE, 32'd1200, 1'b0, 11'sd0);
    send_item(REQ_QUERY, 32'd1300, 1'b0, 11'sd0);
    // reverse edge gives a negative speed
    send_item(REQ_EDGE, 32'd2000, 1'b1, 11'sd0);
    send_item(REQ_QUERY, 32'd2100, 1'b0, 11'sd0);
    // age exactly at the timeout, then one past it
    send_item(REQ_QUERY, 32'd12000, 1'b0, 11'sd0);
    send_item(REQ_QUERY, 32'd12001, 1'b0, 11'sd0);
    // another edge at the same time stamp: zero period
    send_item(REQ_EDGE, 32'd2000, 1'b1, 11'sd0);
    send_item(REQ_QUERY, 32'd2000, 1'b0, 11'sd0);
    // position goes below zero, timestamp wraps between edges
    send_item(REQ_EDGE, 32'hFFFF_FF00, 1'b1, 11'sd0);
    send_item(REQ_EDGE, 32'h0000_0100, 1'b1, 11'sd0);
    send_item(REQ_QUERY, 32'h0000_0180, 1'b0, 11'sd0);
    // unknown request code must vanish without a trace
    send_item(REQ_UNUSED, 32'hFFFF_FFFF, 1'b1, -11'sd1);
    drain();
    // reversed, no noise floor, zero ticks treated as one: speed saturates
    apply_config(1'b1, 20'hFFFFF, 16'd0, 13'd0);
    send_item(REQ_EDGE, 32'h0000_0101, 1'b0, 11'sd0);
    send_item(REQ_QUERY, 32'h0000_0101, 1'b0, 11'sd0);
    send_item(REQ_DRIVE, 32'h0000_0102, 1'b0, 11'sd200);
    send_item(REQ_DRIVE, 32'h0000_0103, 1'b0, -11'sd300);
    drain();
    stamp_us = 32'h0000_0200;
  endtask

  // mostly plausible edge and query timing around the current settings, some noise
  task random_items(int count);
    int i, pick, sel, d;
    bit [1:0]  req;
    bit [31:0] now, step;
    bit        dir;
    bit signed [10:0] drv;
    for (i = 0; i < count; i++) begin
      // hold off once mid-phase until the block has answered everything
      if (i == count / 2) begin
        in_tvalid <= 1'b0;
        do @(posedge clk); while (sb.outstanding() != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 40)      req = REQ_EDGE;
      else if (pick < 72) req = REQ_QUERY;
      else if (pick < 94) req = REQ_DRIVE;
      else                req = REQ_UNUSED;
      sel = $urandom_range(0, 9);
      if ($urandom_range(0, 19) == 0) begin
        now = $urandom();
        stamp_us = now;
      end else begin
        case (req)
          REQ_EDGE: begin
            if (sel < 6)
              step = $urandom_range(sb.min_period_us / 2, sb.min_period_us * 3 + 40);
            else if (sel < 9)
              step = $urandom_range(0, sb.stale_limit_us + 200);
            else
              step = $urandom_range(0, 2000000);
          end
          REQ_QUERY: begin
            if (sel < 7) step = $urandom_range(0, sb.stale_limit_us / 2 + 20);
            else         step = $urandom_range(0, sb.stale_limit_us * 2 + 100);
          end
          default: step = $urandom_range(0, 1000);
        endcase
        stamp_us = stamp_us + step;
        now = stamp_us;
      end
      dir = 1'($urandom_range(0, 1));
      if (sel < 5) begin
        drv = 11'($urandom_range(0, 2047));
      end else begin
        d = int'($urandom_range(0, 600)) - 300;
        drv = d[10:0];
      end
      send_item(req, now, dir, drv);
    end
  endtask

  task run_phase(bit rev, bit [19:0] stale, bit [15:0] minp, bit [12:0] ticks, int count);
    apply_config(rev, stale, minp, ticks);
    random_items(count);
    drain();
  endtask

  // result side: random stall before each result, with stall-free stretches
  initial begin
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) recv_burst = ~recv_burst;
      stall = recv_burst ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_result(out_tuser, out_tdata);
    end
  end

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_items();
    // reset values, then extremes of every register, then a few random settings
    run_phase(1'b0, 20'd10000, 16'd500, 13'd500, 150);
    run_phase(1'b1, 20'd1000000, 16'd0, 13'd1, 130);
    run_phase(1'b0, 20'd0, 16'd65535, 13'd4096, 100);
    run_phase(1'b1, 20'hFFFFF, 16'd1, 13'd8191, 130);
    repeat (3)
      run_phase(1'($urandom_range(0, 1)), 20'($urandom_range(0, 1000000)),
                16'($urandom_range(0, 3000)), 13'($urandom_range(1, 4096)), 100);
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
